// File: hw/rtl/sdmn_pkg.sv
// Package for the signed division magic number generator: microcode types and program ROM.
package sdmn_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned StepWidth  = 3;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned PWidth     = 6;

   localparam logic [DataWidth-1:0] Two31  = 32'h8000_0000;
   localparam logic [PWidth-1:0]    PStart = 6'd31;
   localparam logic [PWidth-1:0]    PBase  = 6'd32;
   localparam logic [PWidth-1:0]    PLimit = 6'd63;
   localparam logic [CountWidth-1:0] CountLast = 5'd31;

   typedef logic [StepWidth-1:0] step_type;

   typedef enum logic [2:0] {
      OP_START   = 3'd0,
      OP_DIV_ANC = 3'd1,
      OP_DIV_Q1  = 3'd2,
      OP_DIV_Q2  = 3'd3,
      OP_LOOP    = 3'd4,
      OP_FINISH  = 3'd5,
      OP_REJECT  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT = 3'd0,
      COND_REJ  = 3'd1,
      COND_DIV  = 3'd2,
      COND_LOOP = 3'd3,
      COND_OUT  = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   localparam step_type StepStart  = 3'd0;
   localparam step_type StepReject = 3'd6;

   function automatic ctrl_word_type program_rom(input step_type step);
      ctrl_word_type cw;
      case (step)
         3'd0: cw = '{op: OP_START,   cond: COND_REJ,  target: StepReject};
         3'd1: cw = '{op: OP_DIV_ANC, cond: COND_DIV,  target: StepStart};
         3'd2: cw = '{op: OP_DIV_Q1,  cond: COND_DIV,  target: StepStart};
         3'd3: cw = '{op: OP_DIV_Q2,  cond: COND_DIV,  target: StepStart};
         3'd4: cw = '{op: OP_LOOP,    cond: COND_LOOP, target: StepStart};
         3'd5: cw = '{op: OP_FINISH,  cond: COND_OUT,  target: StepStart};
         3'd6: cw = '{op: OP_REJECT,  cond: COND_OUT,  target: StepStart};
         default: cw = '{op: OP_REJECT, cond: COND_OUT, target: StepStart};
      endcase
      return cw;
   endfunction

endpackage

// File: hw/rtl/signed_div_magic_number.sv
// Signed division magic number generator: microcoded sequencer over a shared divider.
//
// req_ channel: one word carries a signed 32-bit divisor. req_ready is high while
// no divisor is being worked on; a divisor is taken when req_valid and req_ready
// are both high.
// rsp_ channel: one word per divisor with valid_res, magic, shift_amount and
// correction. Divisors -1, 0 and 1 give valid_res low and zero fields.
// Sequence: a rejected divisor goes from the setup step straight to the reject step,
// which writes the output. Otherwise the setup step, three passes of the restoring divider
// (anc, q1/r1, q2/r2), the doubling loop and the output step follow in turn; the loop
// repeats while the magic number test asks for it and p stays below its limit.
// The shared divider yields one quotient bit per cycle.
// Throughput: one divisor at a time; the next one is taken once the result has
// been written to the output register, so a result waiting on rsp_ready does
// not hold off the next divisor's work.
// Stall: if the output register is still full when a new result is ready, the
// sequencer holds its last step until rsp_ready frees it.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
module signed_div_magic_number (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_divisor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid_res,
   output logic signed [31:0] rsp_magic,
   output logic        [4:0]  rsp_shift_amount,
   output logic signed [1:0]  rsp_correction
);

   localparam int unsigned W = sdmn_pkg::DataWidth;

   logic                          busy_ff, busy_in;
   sdmn_pkg::step_type            step_ff, step_in;
   logic [W-1:0]                  div_ff, div_in;
   logic                          neg_ff, neg_in;
   logic [W-1:0]                  ad_ff, ad_in;
   logic [W-1:0]                  t_ff, t_in;
   logic [W-1:0]                  anc_ff, anc_in;
   logic [W-1:0]                  q1_ff, q1_in;
   logic [W-1:0]                  r1_ff, r1_in;
   logic [W-1:0]                  q2_ff, q2_in;
   logic [W-1:0]                  r2_ff, r2_in;
   logic [sdmn_pkg::PWidth-1:0]   p_ff, p_in;
   logic [W-1:0]                  dq_ff, dq_in;
   logic [W-1:0]                  rem_ff, rem_in;
   logic [sdmn_pkg::CountWidth-1:0] cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_vres_ff, rsp_vres_in;
   logic [W-1:0]                  rsp_magic_ff, rsp_magic_in;
   logic [4:0]                    rsp_shift_ff, rsp_shift_in;
   logic [1:0]                    rsp_corr_ff, rsp_corr_in;

   sdmn_pkg::ctrl_word_type       cw;
   logic                          in_fire;
   logic                          out_free;
   logic                          reject;
   logic                          cnt_last;

   logic [W-1:0]                  dv;
   logic [W:0]                    rem_sh;
   logic [W:0]                    rem_sub;
   logic                          rem_ge;
   logic [W-1:0]                  rem_nx;
   logic [W-1:0]                  dq_nx;

   logic [W-1:0]                  r1_dbl, r2_dbl;
   logic                          r1_ge, r2_ge;
   logic [W-1:0]                  q1_nx, r1_nx, q2_nx, r2_nx;
   logic [W-1:0]                  delta;
   logic [sdmn_pkg::PWidth-1:0]   p_nx;
   logic                          loop_more;

   logic [W-1:0]                  mu;
   logic [sdmn_pkg::PWidth-1:0]   p_rel;

   assign cw        = sdmn_pkg::program_rom(step_ff);
   assign req_ready = !busy_ff;
   assign in_fire   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign reject    = (div_ff == '0) || (div_ff == W'(1)) || (div_ff == '1);
   assign cnt_last  = (cnt_ff == sdmn_pkg::CountLast);

   // restoring divider, one quotient bit per cycle
   always_comb begin
      case (cw.op)
         sdmn_pkg::OP_DIV_Q1: dv = anc_ff;
         default:             dv = ad_ff;
      endcase
   end

   assign rem_sh  = {rem_ff, dq_ff[W-1]};
   assign rem_sub = rem_sh - {1'b0, dv};
   assign rem_ge  = (rem_sh >= {1'b0, dv});
   assign rem_nx  = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
   assign dq_nx   = {dq_ff[W-2:0], rem_ge};

   // one doubling-loop iteration, modulo 2^32
   assign r1_dbl    = {r1_ff[W-2:0], 1'b0};
   assign r2_dbl    = {r2_ff[W-2:0], 1'b0};
   assign r1_ge     = (r1_dbl >= anc_ff);
   assign r2_ge     = (r2_dbl >= ad_ff);
   assign q1_nx     = {q1_ff[W-2:0], r1_ge};
   assign r1_nx     = r1_ge ? (r1_dbl - anc_ff) : r1_dbl;
   assign q2_nx     = {q2_ff[W-2:0], r2_ge};
   assign r2_nx     = r2_ge ? (r2_dbl - ad_ff) : r2_dbl;
   assign delta     = ad_ff - r2_nx;
   assign p_nx      = p_ff + sdmn_pkg::PWidth'(1);
   assign loop_more = ((q1_nx < delta) || ((q1_nx == delta) && (r1_nx == '0)))
                      && (p_nx < sdmn_pkg::PLimit);

   assign mu    = q2_ff + W'(1);
   assign p_rel = p_ff - sdmn_pkg::PBase;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      ad_in        = ad_ff;
      t_in         = t_ff;
      anc_in       = anc_ff;
      q1_in        = q1_ff;
      r1_in        = r1_ff;
      q2_in        = q2_ff;
      r2_in        = r2_ff;
      p_in         = p_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vres_in  = rsp_vres_ff;
      rsp_magic_in = rsp_magic_ff;
      rsp_shift_in = rsp_shift_ff;
      rsp_corr_in  = rsp_corr_ff;

      if (in_fire) begin
         busy_in = 1'b1;
         step_in = sdmn_pkg::StepStart;
         div_in  = req_divisor;
      end else if (busy_ff) begin
         // datapath
         case (cw.op)
            sdmn_pkg::OP_START: begin
               neg_in = div_ff[W-1];
               ad_in  = div_ff[W-1] ? (W'(0) - div_ff) : div_ff;
               t_in   = sdmn_pkg::Two31 + W'(div_ff[W-1]);
               dq_in  = sdmn_pkg::Two31 + W'(div_ff[W-1]);
               rem_in = '0;
               cnt_in = '0;
            end
            sdmn_pkg::OP_DIV_ANC, sdmn_pkg::OP_DIV_Q1, sdmn_pkg::OP_DIV_Q2: begin
               dq_in  = dq_nx;
               rem_in = rem_nx;
               cnt_in = cnt_ff + sdmn_pkg::CountWidth'(1);
               if (cnt_last) begin
                  dq_in  = sdmn_pkg::Two31;
                  rem_in = '0;
                  case (cw.op)
                     sdmn_pkg::OP_DIV_ANC: anc_in = t_ff - W'(1) - rem_nx;
                     sdmn_pkg::OP_DIV_Q1: begin
                        q1_in = dq_nx;
                        r1_in = rem_nx;
                     end
                     default: begin
                        q2_in = dq_nx;
                        r2_in = rem_nx;
                        p_in  = sdmn_pkg::PStart;
                     end
                  endcase
               end
            end
            sdmn_pkg::OP_LOOP: begin
               q1_in = q1_nx;
               r1_in = r1_nx;
               q2_in = q2_nx;
               r2_in = r2_nx;
               p_in  = p_nx;
            end
            sdmn_pkg::OP_FINISH: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_vres_in  = 1'b1;
                  rsp_magic_in = neg_ff ? (W'(0) - mu) : mu;
                  rsp_shift_in = p_rel[4:0];
                  if (mu[W-1]) begin
                     rsp_corr_in = neg_ff ? 2'b11 : 2'b01;
                  end else begin
                     rsp_corr_in = 2'b00;
                  end
               end
            end
            default: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_vres_in  = 1'b0;
                  rsp_magic_in = '0;
                  rsp_shift_in = '0;
                  rsp_corr_in  = '0;
               end
            end
         endcase

         // sequencer
         case (cw.cond)
            sdmn_pkg::COND_REJ: begin
               step_in = reject ? cw.target : step_ff + sdmn_pkg::StepWidth'(1);
            end
            sdmn_pkg::COND_DIV: begin
               if (cnt_last) begin
                  step_in = step_ff + sdmn_pkg::StepWidth'(1);
               end
            end
            sdmn_pkg::COND_LOOP: begin
               if (!loop_more) begin
                  step_in = step_ff + sdmn_pkg::StepWidth'(1);
               end
            end
            sdmn_pkg::COND_OUT: begin
               if (out_free) begin
                  busy_in = 1'b0;
                  step_in = cw.target;
               end
            end
            default: step_in = step_ff + sdmn_pkg::StepWidth'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= sdmn_pkg::StepStart;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      ad_ff        <= ad_in;
      t_ff         <= t_in;
      anc_ff       <= anc_in;
      q1_ff        <= q1_in;
      r1_ff        <= r1_in;
      q2_ff        <= q2_in;
      r2_ff        <= r2_in;
      p_ff         <= p_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_vres_ff  <= rsp_vres_in;
      rsp_magic_ff <= rsp_magic_in;
      rsp_shift_ff <= rsp_shift_in;
      rsp_corr_ff  <= rsp_corr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_valid_res    = rsp_vres_ff;
   assign rsp_magic        = rsp_magic_ff;
   assign rsp_shift_amount = rsp_shift_ff;
   assign rsp_correction   = rsp_corr_ff;

endmodule

// File: verif/sdmn_checker.sv
// Checker for the magic number generator: predicts each result word and compares it.
`timescale 1ns / 1ps

module sdmn_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_divisor,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_valid_res,
   input  logic signed [31:0] rsp_magic,
   input  logic        [4:0]  rsp_shift_amount,
   input  logic signed [1:0]  rsp_correction,
   output int                 failures,
   output int                 pending
);

   typedef struct packed {
      logic [31:0]        divisor;
      logic               valid_res;
      logic [31:0]        magic;
      logic [4:0]         shift_amount;
      logic signed [1:0]  correction;
   } magic_word_type;

   magic_word_type expected_words[$];

   function automatic magic_word_type derive_magic(input logic [31:0] d);
      magic_word_type w;
      logic        neg;
      logic [31:0] ad, t, anc, q1, r1, q2, r2, delta, mu;
      int          p;
      longint      m;
      w = '0;
      w.divisor = d;
      neg = d[31];
      if (d == 32'd0 || d == 32'd1 || d == 32'hFFFF_FFFF) begin
         return w;
      end
      ad  = neg ? (32'd0 - d) : d;
      t   = sdmn_pkg::Two31 + {31'd0, d[31]};
      anc = t - 32'd1 - (t % ad);
      p   = int'(sdmn_pkg::PStart);
      q1  = sdmn_pkg::Two31 / anc;
      r1  = sdmn_pkg::Two31 - q1 * anc;
      q2  = sdmn_pkg::Two31 / ad;
      r2  = sdmn_pkg::Two31 - q2 * ad;
      do begin
         p++;
         q1 = q1 * 2;
         r1 = r1 * 2;
         if (r1 >= anc) begin
            q1 = q1 + 1;
            r1 = r1 - anc;
         end
         q2 = q2 * 2;
         r2 = r2 * 2;
         if (r2 >= ad) begin
            q2 = q2 + 1;
            r2 = r2 - ad;
         end
         delta = ad - r2;
      end while ((q1 < delta || (q1 == delta && r1 == 32'd0)) &&
                 p < int'(sdmn_pkg::PLimit));
      mu = q2 + 32'd1;
      m  = longint'(signed'(mu));
      if (neg) begin
         m = -m;
         if (m > 0) w.correction = -2'sd1;
      end else if (m < 0) begin
         w.correction = 2'sd1;
      end
      w.valid_res    = 1'b1;
      w.magic        = m[31:0];
      w.shift_amount = 5'(p - int'(sdmn_pkg::PBase));
      return w;
   endfunction

   initial begin
      failures = 0;
      pending  = 0;
   end

   always @(posedge clock) begin
      magic_word_type exp_w;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_words = {expected_words, derive_magic(req_divisor)};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("unexpected word: valid_res=%0b magic=%h shift=%0d corr=%0d",
                           rsp_valid_res, rsp_magic, rsp_shift_amount, rsp_correction);
               end
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_valid_res !== exp_w.valid_res || rsp_magic !== exp_w.magic ||
                   rsp_shift_amount !== exp_w.shift_amount ||
                   rsp_correction !== exp_w.correction) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("mismatch divisor=%h exp: %0b %h %0d %0d got: %0b %h %0d %0d",
                              exp_w.divisor, exp_w.valid_res, exp_w.magic,
                              exp_w.shift_amount, exp_w.correction, rsp_valid_res,
                              rsp_magic, rsp_shift_amount, rsp_correction);
                  end
               end
            end
         end
         pending = expected_words.size();
      end
   end

endmodule

// File: verif/tb_top.sv
// Top of the magic number generator testbench: clock, reset, divisor stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int CycleLimit  = 900000;
   localparam int RandomCount = 1025;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_divisor;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_valid_res;
   logic signed [31:0] rsp_magic;
   logic        [4:0]  rsp_shift_amount;
   logic signed [1:0]  rsp_correction;

   int failures;
   int pending;
   int cycles = 0;
   bit steady = 1'b0;

   logic [31:0] directed_divisors[25] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd3, 32'hFFFF_FFFD,
      32'd5, 32'hFFFF_FFFB, 32'd6, 32'd7, 32'hFFFF_FFF9, 32'd641, 32'hFFFF_FD7F,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h4000_0000, 32'hC000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'd25, 32'd125, 32'hFFFF_FF83
   };

   signed_div_magic_number dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_divisor      (req_divisor),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_magic        (rsp_magic),
      .rsp_shift_amount (rsp_shift_amount),
      .rsp_correction   (rsp_correction)
   );

   sdmn_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_divisor      (req_divisor),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_magic        (rsp_magic),
      .rsp_shift_amount (rsp_shift_amount),
      .rsp_correction   (rsp_correction),
      .failures         (failures),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic logic [31:0] random_divisor();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom_range(2, 1000);
         3:       v = 32'd1 << $urandom_range(1, 31);
         4: begin
            case ($urandom_range(0, 5))
               0: v = 32'd0;
               1: v = 32'd1;
               2: v = 32'h7FFF_FFFF;
               3: v = 32'h8000_0000;
               4: v = 32'h8000_0001;
               default: v = $urandom_range(2, 65535);
            endcase
         end
         default: v = $urandom;
      endcase
      if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
      return v;
   endfunction

   task automatic send_divisor(input logic [31:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_divisor <= d;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // result side: one stall draw per word
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_divisor = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_divisors[i]) send_divisor(directed_divisors[i]);

      for (int i = 0; i < RandomCount; i++) begin
         steady = ((i / 80) % 5) == 4;
         if (i == 600) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         send_divisor(random_divisor());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (140) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
